[sv/srbe_pkg.sv]
// Shared types, constants and elaboration-time functions of the sensor ring bearing estimator.
package srbe_pkg;

   localparam int LIMIT_BITS    = 10;
   localparam int SENSOR_BITS   = 5;
   localparam int CSR_DATA_BITS = 10;
   localparam int CSR_INDEX_BITS = 2;
   localparam int BEARING_BITS  = 15;
   localparam int TRIG_STEPS    = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LIMIT      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LIMIT     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATCH_ENABLE   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATCHED_SENSOR = 2'd3;

   localparam logic [LIMIT_BITS-1:0]  LOW_LIMIT_RESET      = 10'd5;
   localparam logic [LIMIT_BITS-1:0]  HIGH_LIMIT_RESET     = 10'd1020;
   localparam logic                   PATCH_ENABLE_RESET   = 1'b1;
   localparam logic [SENSOR_BITS-1:0] PATCHED_SENSOR_RESET = 5'd15;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam longint      GAIN_Q30     = 64'sd652032874;

   localparam logic [31:0] ATAN_TURN [TRIG_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic [LIMIT_BITS-1:0]  low_limit;
      logic [LIMIT_BITS-1:0]  high_limit;
      logic                   patch_enable;
      logic [SENSOR_BITS-1:0] patched_sensor;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } scan_job_type;

   typedef struct packed {
      logic signed [63:0] c;
      logic signed [63:0] s;
   } trig_pair_type;

   // Rotation CORDIC in Q30, rounded half up to frac fraction bits.
   function automatic trig_pair_type sensor_trig(logic [31:0] ang, int frac);
      trig_pair_type res;
      logic [31:0]   a;
      logic          flip;
      longint        x;
      longint        y;
      longint        z;
      longint        dx;
      longint        dy;
      int            sh;
      a    = ang;
      flip = 1'b0;
      x    = GAIN_Q30;
      y    = 0;
      sh   = 30 - frac;
      if (a >= QUARTER_TURN && a < 32'hC000_0000) begin
         a    = a - HALF_TURN;
         flip = 1'b1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < TRIG_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'({32'd0, ATAN_TURN[i]});
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'({32'd0, ATAN_TURN[i]});
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      res.c = (x + (64'sd1 <<< (sh - 1))) >>> sh;
      res.s = (y + (64'sd1 <<< (sh - 1))) >>> sh;
      return res;
   endfunction

endpackage

[sv/srbe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module srbe_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/srbe_front.sv]
// Front end: counts readings of a scan into a capture bank and posts completed scans.
module srbe_front #(
   parameter int NUM_SENSORS = 24,
   parameter int SAMPLE_BITS = 10,
   localparam int IDX_W = $clog2(NUM_SENSORS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic                     start_of_scan,
   output logic                     cap_wr_en,
   output logic [IDX_W:0]           cap_wr_addr,
   output logic [SAMPLE_BITS-1:0]   cap_wr_data,
   output srbe_pkg::scan_job_type   job
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_SENSORS - 1);

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic             bank_ff;
   logic             bank_in;
   logic [IDX_W-1:0] idx;
   logic             last;

   // A start mark restarts the count at sensor 0.
   assign idx  = start_of_scan ? '0 : count_ff;
   assign last = (idx == LAST);

   assign cap_wr_en   = accept;
   assign cap_wr_addr = {bank_ff, idx};
   assign cap_wr_data = sample;

   assign job.valid = accept && last;
   assign job.bank  = bank_ff;

   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            bank_in  = ~bank_ff;
         end else begin
            count_in = idx + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

[sv/srbe_queue.sv]
// One-slot queue of completed scans between front and back.
module srbe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  srbe_pkg::scan_job_type push_job,
   input  logic                   pop,
   output srbe_pkg::scan_job_type head,
   output logic                   full
);

   logic valid_ff;
   logic valid_in;
   logic bank_ff;

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b0;
      end
      if (push_job.valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push_job.valid) begin
         bank_ff <= push_job.bank;
      end
   end

   assign head.valid = valid_ff;
   assign head.bank  = bank_ff;
   assign full       = valid_ff;

endmodule

[sv/srbe_back.sv]
// Back end: copies a scan, repairs it, sums weighted vectors and runs the atan2 CORDIC.
module srbe_back #(
   parameter int NUM_SENSORS       = 24,
   parameter int SAMPLE_BITS       = 10,
   parameter int TRIG_FRAC_BITS    = 14,
   parameter int CORDIC_ITERATIONS = 16,
   parameter int ANGLE_FRAC_BITS   = 6,
   localparam int IDX_W = $clog2(NUM_SENSORS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srbe_pkg::cfg_type                   cfg,
   input  srbe_pkg::scan_job_type              job,
   output logic                                pop,
   output logic [IDX_W:0]                      cap_rd_addr,
   input  logic [SAMPLE_BITS-1:0]              cap_rd_data,
   output logic                                rsp_valid,
   output logic [srbe_pkg::BEARING_BITS-1:0]   rsp_bearing,
   output logic                                rsp_vector_zero
);

   localparam int TW       = TRIG_FRAC_BITS + 2;
   localparam int PROD_W   = SAMPLE_BITS + 1 + TW;
   localparam int SUM_W    = PROD_W + IDX_W;
   localparam int NORM_MAG = (SUM_W - 1 > 41) ? SUM_W - 1 : 41;
   localparam int CW       = NORM_MAG + 3;
   localparam int IT_W     = $clog2(CORDIC_ITERATIONS);
   localparam int CMP_W    = (SAMPLE_BITS > srbe_pkg::LIMIT_BITS) ?
                             SAMPLE_BITS : srbe_pkg::LIMIT_BITS;
   localparam int FULL_W   = $clog2((360 << ANGLE_FRAC_BITS) + 1);
   localparam int MUL_W    = 32 + FULL_W;

   localparam logic [IDX_W-1:0]     LAST     = IDX_W'(NUM_SENSORS - 1);
   localparam logic [IDX_W:0]       COUNT_N  = (IDX_W + 1)'(NUM_SENSORS);
   localparam logic [IT_W-1:0]      IT_LAST  = IT_W'(CORDIC_ITERATIONS - 1);
   localparam logic signed [CW-1:0] NORM_LIM = CW'(64'sd1 <<< 40);
   localparam logic signed [CW-1:0] NORM_NEG = -NORM_LIM;
   localparam logic [FULL_W-1:0]    FULL     = FULL_W'(360 << ANGLE_FRAC_BITS);
   localparam logic [srbe_pkg::BEARING_BITS-1:0] ZERO_BEARING =
      srbe_pkg::BEARING_BITS'(180 << ANGLE_FRAC_BITS);

   typedef enum logic [4:0] {
      S_IDLE, S_COPY, S_RD_CUR, S_RD_LEFT, S_RD_RIGHT, S_FIX,
      S_P_LEFT, S_P_RIGHT, S_P_FIX, S_SUM_RD, S_SUM_MUL, S_SUM_ACC,
      S_CHECK, S_NORM, S_ITER, S_SCALE, S_ROUND
   } state_type;

   state_type state_ff;

   logic [IDX_W-1:0]          idx_ff;
   logic [IDX_W:0]            cnt_ff;
   logic                      bank_ff;
   logic [SAMPLE_BITS-1:0]    v_ff;
   logic [SAMPLE_BITS-1:0]    l_ff;
   logic signed [PROD_W-1:0]  px_ff;
   logic signed [PROD_W-1:0]  py_ff;
   logic signed [SUM_W-1:0]   sx_ff;
   logic signed [SUM_W-1:0]   sy_ff;
   logic signed [CW-1:0]      xs_ff;
   logic signed [CW-1:0]      ys_ff;
   logic [31:0]               z_ff;
   logic [IT_W-1:0]           it_ff;
   logic [MUL_W-1:0]          mul_ff;
   logic                      rsp_valid_ff;
   logic [srbe_pkg::BEARING_BITS-1:0] rsp_bearing_ff;
   logic                      rsp_zero_ff;

   logic signed [TW-1:0] cos_tab [NUM_SENSORS];
   logic signed [TW-1:0] sin_tab [NUM_SENSORS];

   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_trig
      localparam logic [31:0] ANG = 32'((64'(g) << 32) / NUM_SENSORS);
      localparam srbe_pkg::trig_pair_type TP =
         srbe_pkg::sensor_trig(ANG, TRIG_FRAC_BITS);
      assign cos_tab[g] = TW'(TP.c);
      assign sin_tab[g] = TW'(TP.s);
   end

   function automatic logic [IDX_W-1:0] left_of(logic [IDX_W-1:0] i);
      return (i == '0) ? LAST : i - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] right_of(logic [IDX_W-1:0] i);
      return (i == LAST) ? '0 : i + 1'b1;
   endfunction

   logic                   wk_wr_en;
   logic [IDX_W-1:0]       wk_wr_addr;
   logic [SAMPLE_BITS-1:0] wk_wr_data;
   logic [IDX_W-1:0]       wk_rd_addr;
   logic [SAMPLE_BITS-1:0] wk_rd_data;

   srbe_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (NUM_SENSORS)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (wk_wr_en),
      .wr_addr (wk_wr_addr),
      .wr_data (wk_wr_data),
      .rd_addr (wk_rd_addr),
      .rd_data (wk_rd_data)
   );

   logic [IDX_W:0]         cnt_m1;
   logic [SAMPLE_BITS:0]   pair_sum;
   logic [SAMPLE_BITS-1:0] mean;
   logic                   invalid;
   logic                   patch_on;
   logic [IDX_W-1:0]       p_idx;
   logic signed [CW-1:0]   sx_ext;
   logic signed [CW-1:0]   sy_ext;
   logic signed [CW-1:0]   dx;
   logic signed [CW-1:0]   dy;
   logic [31:0]            z_half;
   logic [MUL_W-1:0]       rnd;
   logic [FULL_W-1:0]      braw;

   assign cnt_m1   = cnt_ff - 1'b1;
   assign pair_sum = {1'b0, l_ff} + {1'b0, wk_rd_data};
   assign mean     = pair_sum[SAMPLE_BITS:1];
   assign invalid  = (CMP_W'(v_ff) > CMP_W'(cfg.high_limit)) ||
                     (CMP_W'(v_ff) < CMP_W'(cfg.low_limit));
   assign patch_on = cfg.patch_enable && (cfg.patched_sensor < NUM_SENSORS);
   assign p_idx    = IDX_W'(cfg.patched_sensor);
   assign sx_ext   = CW'(sx_ff);
   assign sy_ext   = CW'(sy_ff);
   assign dx       = ys_ff >>> it_ff;
   assign dy       = xs_ff >>> it_ff;
   // Turn half a turn, wrapping on the full circle.
   assign z_half   = z_ff + srbe_pkg::HALF_TURN;
   assign rnd      = mul_ff + MUL_W'(srbe_pkg::HALF_TURN);
   assign braw     = rnd[MUL_W-1:32];

   assign pop         = (state_ff == S_IDLE) && job.valid;
   assign cap_rd_addr = {bank_ff, cnt_ff[IDX_W-1:0]};

   always_comb begin
      wk_wr_en   = 1'b0;
      wk_wr_addr = idx_ff;
      wk_wr_data = mean;
      wk_rd_addr = idx_ff;
      unique case (state_ff)
         S_COPY: begin
            wk_wr_en   = (cnt_ff != '0);
            wk_wr_addr = cnt_m1[IDX_W-1:0];
            wk_wr_data = cap_rd_data;
         end
         S_RD_LEFT:  wk_rd_addr = left_of(idx_ff);
         S_RD_RIGHT: wk_rd_addr = right_of(idx_ff);
         S_FIX:      wk_wr_en   = invalid;
         S_P_LEFT:   wk_rd_addr = left_of(p_idx);
         S_P_RIGHT:  wk_rd_addr = right_of(p_idx);
         S_P_FIX: begin
            wk_wr_en   = 1'b1;
            wk_wr_addr = p_idx;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job.valid) begin
                  bank_ff  <= job.bank;
                  cnt_ff   <= '0;
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == COUNT_N) begin
                  idx_ff   <= '0;
                  state_ff <= S_RD_CUR;
               end
            end
            S_RD_CUR:   state_ff <= S_RD_LEFT;
            S_RD_LEFT: begin
               v_ff     <= wk_rd_data;
               state_ff <= S_RD_RIGHT;
            end
            S_RD_RIGHT: begin
               l_ff     <= wk_rd_data;
               state_ff <= S_FIX;
            end
            S_FIX, S_P_FIX: begin
               if (state_ff == S_FIX && patch_on) begin
                  state_ff <= S_P_LEFT;
               end else if (idx_ff == LAST) begin
                  idx_ff   <= '0;
                  sx_ff    <= '0;
                  sy_ff    <= '0;
                  state_ff <= S_SUM_RD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD_CUR;
               end
            end
            S_P_LEFT:   state_ff <= S_P_RIGHT;
            S_P_RIGHT: begin
               l_ff     <= wk_rd_data;
               state_ff <= S_P_FIX;
            end
            S_SUM_RD:   state_ff <= S_SUM_MUL;
            S_SUM_MUL: begin
               px_ff    <= PROD_W'($signed({1'b0, wk_rd_data})) * PROD_W'(cos_tab[idx_ff]);
               py_ff    <= PROD_W'($signed({1'b0, wk_rd_data})) * PROD_W'(sin_tab[idx_ff]);
               state_ff <= S_SUM_ACC;
            end
            S_SUM_ACC: begin
               sx_ff <= sx_ff + SUM_W'(px_ff);
               sy_ff <= sy_ff + SUM_W'(py_ff);
               if (idx_ff == LAST) begin
                  state_ff <= S_CHECK;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SUM_RD;
               end
            end
            S_CHECK: begin
               if (sx_ff == '0 && sy_ff == '0) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_bearing_ff <= ZERO_BEARING;
                  rsp_zero_ff    <= 1'b1;
                  state_ff       <= S_IDLE;
               end else begin
                  // Fold the left half plane onto the right one.
                  if (sx_ff < 0) begin
                     xs_ff <= -sx_ext;
                     ys_ff <= -sy_ext;
                     z_ff  <= srbe_pkg::HALF_TURN;
                  end else begin
                     xs_ff <= sx_ext;
                     ys_ff <= sy_ext;
                     z_ff  <= '0;
                  end
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (xs_ff < NORM_LIM && xs_ff > NORM_NEG &&
                   ys_ff < NORM_LIM && ys_ff > NORM_NEG) begin
                  xs_ff <= xs_ff <<< 1;
                  ys_ff <= ys_ff <<< 1;
               end else begin
                  it_ff    <= '0;
                  state_ff <= S_ITER;
               end
            end
            S_ITER: begin
               if (ys_ff > 0) begin
                  xs_ff <= xs_ff + dx;
                  ys_ff <= ys_ff - dy;
                  z_ff  <= z_ff + srbe_pkg::ATAN_TURN[5'(it_ff)];
               end else begin
                  xs_ff <= xs_ff - dx;
                  ys_ff <= ys_ff + dy;
                  z_ff  <= z_ff - srbe_pkg::ATAN_TURN[5'(it_ff)];
               end
               it_ff <= it_ff + 1'b1;
               if (it_ff == IT_LAST) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               mul_ff   <= MUL_W'(z_half) * MUL_W'(FULL);
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               rsp_valid_ff   <= 1'b1;
               rsp_bearing_ff <= srbe_pkg::BEARING_BITS'((braw == '0) ? FULL : braw);
               rsp_zero_ff    <= 1'b0;
               state_ff       <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bearing     = rsp_bearing_ff;
   assign rsp_vector_zero = rsp_zero_ff;

endmodule

[sv/sensor_ring_bearing_estimator.sv]
// Top level of the sensor ring bearing estimator: registers, capture RAM, front, queue, back.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------------
//  request  | req_sample, req_start_of_scan           | taken when start=1 and busy=0
//  response | rsp_bearing, rsp_vector_zero            | rsp_valid strobe, one cycle
//  csr      | csr_index, csr_write_data               | written when csr_write_enable=1
//
// Readings are taken one per cycle while busy is low, into one of two capture banks; a
// completed scan is a transaction handed through a one-slot queue to the back end. busy is
// high while the slot is occupied, i.e. while both banks belong to the back end. Per scan
// the back end copies the scan into its work RAM, repairs each sensor (and, with the patch
// on, the patched sensor after each), sums weighted vectors, normalises, rotates in
// CORDIC_ITERATIONS steps, scales and rounds, paced by its single work-RAM read port.
// Synchronous reset clears counters, queue slot and strobe; no memory is cleared.
// The response side cannot stall: each result is shown for exactly one cycle.
module sensor_ring_bearing_estimator #(
   parameter int NUM_SENSORS       = 24,
   parameter int SAMPLE_BITS       = 10,
   parameter int TRIG_FRAC_BITS    = 14,
   parameter int CORDIC_ITERATIONS = 16,
   parameter int ANGLE_FRAC_BITS   = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [SAMPLE_BITS-1:0]                req_sample,
   input  logic                                  req_start_of_scan,
   output logic                                  rsp_valid,
   output logic [srbe_pkg::BEARING_BITS-1:0]     rsp_bearing,
   output logic                                  rsp_vector_zero,
   input  logic                                  csr_write_enable,
   input  logic [srbe_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srbe_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   localparam int IDX_W = $clog2(NUM_SENSORS);

   srbe_pkg::cfg_type      cfg_ff;
   srbe_pkg::cfg_type      cfg_in;
   srbe_pkg::scan_job_type push_job;
   srbe_pkg::scan_job_type head_job;

   logic                   accept;
   logic                   pop;
   logic                   cap_wr_en;
   logic [IDX_W:0]         cap_wr_addr;
   logic [SAMPLE_BITS-1:0] cap_wr_data;
   logic [IDX_W:0]         cap_rd_addr;
   logic [SAMPLE_BITS-1:0] cap_rd_data;

   // Accept a reading when start is high and a capture bank is free.
   assign accept = start && !busy;

   // Register writes; every index value names one of the four registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            srbe_pkg::CSR_LOW_LIMIT:      cfg_in.low_limit      = csr_write_data;
            srbe_pkg::CSR_HIGH_LIMIT:     cfg_in.high_limit     = csr_write_data;
            srbe_pkg::CSR_PATCH_ENABLE:   cfg_in.patch_enable   = csr_write_data[0];
            srbe_pkg::CSR_PATCHED_SENSOR: cfg_in.patched_sensor =
               csr_write_data[srbe_pkg::SENSOR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit      <= srbe_pkg::LOW_LIMIT_RESET;
         cfg_ff.high_limit     <= srbe_pkg::HIGH_LIMIT_RESET;
         cfg_ff.patch_enable   <= srbe_pkg::PATCH_ENABLE_RESET;
         cfg_ff.patched_sensor <= srbe_pkg::PATCHED_SENSOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Two banks, addressed by {bank, sensor}.
   srbe_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (2 << IDX_W)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (cap_wr_en),
      .wr_addr (cap_wr_addr),
      .wr_data (cap_wr_data),
      .rd_addr (cap_rd_addr),
      .rd_data (cap_rd_data)
   );

   srbe_front #(
      .NUM_SENSORS (NUM_SENSORS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .sample        (req_sample),
      .start_of_scan (req_start_of_scan),
      .cap_wr_en     (cap_wr_en),
      .cap_wr_addr   (cap_wr_addr),
      .cap_wr_data   (cap_wr_data),
      .job           (push_job)
   );

   srbe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_job (push_job),
      .pop      (pop),
      .head     (head_job),
      .full     (busy)
   );

   srbe_back #(
      .NUM_SENSORS       (NUM_SENSORS),
      .SAMPLE_BITS       (SAMPLE_BITS),
      .TRIG_FRAC_BITS    (TRIG_FRAC_BITS),
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .job             (head_job),
      .pop             (pop),
      .cap_rd_addr     (cap_rd_addr),
      .cap_rd_data     (cap_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_bearing     (rsp_bearing),
      .rsp_vector_zero (rsp_vector_zero)
   );

endmodule

[sv/srbe_checker.sv]
// Port-level checker for the sensor ring bearing estimator, with its bind.
module srbe_checker #(
   parameter int ANGLE_FRAC_BITS = 6
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [srbe_pkg::BEARING_BITS-1:0] rsp_bearing,
   input logic                              rsp_vector_zero
);

   localparam logic [srbe_pkg::BEARING_BITS-1:0] ZERO_BEARING =
      srbe_pkg::BEARING_BITS'(180 << ANGLE_FRAC_BITS);

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_zero_bearing : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vector_zero) |-> (rsp_bearing == ZERO_BEARING))
      else $error("zero vector without half-turn bearing");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a transaction");

   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe straight after reset");

endmodule

bind sensor_ring_bearing_estimator srbe_checker #(
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_srbe_checker (.*);

[sim/sensor_ring_bearing_estimator_test.sv]
// Self-checking testbench of the sensor ring bearing estimator.
module sensor_ring_bearing_estimator_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING        = 24;
   localparam int SETTLE      = 450;       // idle wait that lets the back end finish its last scan
   localparam int CYCLE_LIMIT = 2_000_000;

   // directed scan shapes
   typedef enum int {SHAPE_FLAT, SHAPE_SPIKE, SHAPE_BROKEN} shape_type;

   typedef struct {
      shape_type        shape;
      int               level;   // reading for the flat part or the spike
      int               spot;    // sensor carrying the spike
      bit               known;   // expected bearing typed in below
      bit [14:0]        bearing;
      bit               zero;
   } scan_row_type;

   typedef struct {
      bit [14:0] bearing;
      bit        zero;
   } bearing_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [9:0]                          req_sample;
   logic                                req_start_of_scan;
   logic                                rsp_valid;
   logic [srbe_pkg::BEARING_BITS-1:0]   rsp_bearing;
   logic                                rsp_vector_zero;
   logic                                csr_write_enable;
   logic [srbe_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [srbe_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   // predictor state
   srbe_pkg::cfg_type cfg;
   int unsigned       ring_store [RING];
   int unsigned       ring_count;
   longint            cos_q [RING];
   longint            sin_q [RING];

   bearing_type pending_bearings [$];
   int          mismatches;
   int          idle_pct;
   longint      cycle_count;

   sensor_ring_bearing_estimator DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_sample        (req_sample),
      .req_start_of_scan (req_start_of_scan),
      .rsp_valid         (rsp_valid),
      .rsp_bearing       (rsp_bearing),
      .rsp_vector_zero   (rsp_vector_zero),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up on a hung block.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Build the per-sensor cos and sin weights: rotation CORDIC in Q30, then round half up.
   task automatic build_weights();
      longint      x, y, z, tx;
      logic [31:0] ang;
      bit          mirror;
      for (int k = 0; k < RING; k++) begin
         ang    = 32'((64'(k) << 32) / RING);
         mirror = (ang >= srbe_pkg::QUARTER_TURN) && (ang < 32'hC000_0000);
         if (mirror) ang -= srbe_pkg::HALF_TURN;
         z = longint'($signed(ang));
         x = 64'sd652032874;
         y = 0;
         for (int s = 0; s < 24; s++) begin
            tx = x;
            if (z >= 0) begin
               x = x - (y >>> s);
               y = y + (tx >>> s);
               z = z - longint'(srbe_pkg::ATAN_TURN[s]);
            end else begin
               x = x + (y >>> s);
               y = y - (tx >>> s);
               z = z + longint'(srbe_pkg::ATAN_TURN[s]);
            end
         end
         if (mirror) begin
            x = -x;
            y = -y;
         end
         cos_q[k] = (x + 64'sd32768) >>> 16;
         sin_q[k] = (y + 64'sd32768) >>> 16;
      end
   endtask

   function automatic int unsigned ring_mean(int k);
      return (ring_store[(k + RING - 1) % RING] + ring_store[(k + 1) % RING]) / 2;
   endfunction

   // Repair, weight and sum a completed scan, then resolve its direction.
   function automatic bearing_type scan_bearing();
      bearing_type res;
      longint      sx, sy, tx;
      logic [31:0] ang;
      logic [63:0] scaled;
      sx = 0;
      sy = 0;
      for (int k = 0; k < RING; k++) begin
         if (ring_store[k] > cfg.high_limit || ring_store[k] < cfg.low_limit)
            ring_store[k] = ring_mean(k);
         if (cfg.patch_enable && cfg.patched_sensor < RING)
            ring_store[cfg.patched_sensor] = ring_mean(cfg.patched_sensor);
      end
      for (int k = 0; k < RING; k++) begin
         sx += longint'(ring_store[k]) * cos_q[k];
         sy += longint'(ring_store[k]) * sin_q[k];
      end
      if (sx == 0 && sy == 0) begin
         res.bearing = 15'd11520;
         res.zero    = 1'b1;
         return res;
      end
      ang = 32'd0;
      if (sx < 0) begin
         sx  = -sx;
         sy  = -sy;
         ang = srbe_pkg::HALF_TURN;
      end
      while ((sx < 0 ? -sx : sx) < (64'sd1 << 40) && (sy < 0 ? -sy : sy) < (64'sd1 << 40)) begin
         sx *= 2;
         sy *= 2;
      end
      for (int s = 0; s < 16; s++) begin
         tx = sx;
         if (sy > 0) begin
            sx  = sx + (sy >>> s);
            sy  = sy - (tx >>> s);
            ang = ang + srbe_pkg::ATAN_TURN[s];
         end else begin
            sx  = sx - (sy >>> s);
            sy  = sy + (tx >>> s);
            ang = ang - srbe_pkg::ATAN_TURN[s];
         end
      end
      ang    = ang + srbe_pkg::HALF_TURN;
      scaled = (64'(ang) * 64'd23040 + 64'h8000_0000) >> 32;
      if (scaled == 0) scaled = 64'd23040;
      res.bearing = scaled[14:0];
      res.zero    = 1'b0;
      return res;
   endfunction

   // Advance the predictor by one accepted reading.
   task automatic take_reading(bit [9:0] value, bit mark);
      int unsigned slot;
      slot = mark ? 0 : ring_count;
      if (slot >= RING) slot = 0;
      ring_store[slot] = value;
      ring_count       = slot + 1;
      if (ring_count == RING) begin
         ring_count = 0;
         pending_bearings = {pending_bearings, scan_bearing()};
      end
   endtask

   // Drive one reading, hold it until the block takes it.
   task automatic send_reading(bit [9:0] value, bit mark);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start             <= 1'b1;
      req_sample        <= value;
      req_start_of_scan <= mark;
      do @(negedge clock); while (busy);
      @(posedge clock);
      take_reading(value, mark);
   endtask

   // Hold the request side off until the block has drained, then write every register.
   task automatic write_registers(srbe_pkg::cfg_type next);
      start <= 1'b0;
      wait (pending_bearings.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= srbe_pkg::CSR_LOW_LIMIT;
      csr_write_data   <= next.low_limit;
      @(posedge clock);
      csr_index        <= srbe_pkg::CSR_HIGH_LIMIT;
      csr_write_data   <= next.high_limit;
      @(posedge clock);
      csr_index        <= srbe_pkg::CSR_PATCH_ENABLE;
      csr_write_data   <= {9'd0, next.patch_enable};
      @(posedge clock);
      csr_index        <= srbe_pkg::CSR_PATCHED_SENSOR;
      csr_write_data   <= {5'd0, next.patched_sensor};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg = next;
   endtask

   function automatic bit [9:0] random_level();
      unique case ($urandom_range(9))
         0:       return 10'd0;
         1:       return 10'd1023;
         2:       return 10'($urandom_range(12));
         3:       return 10'($urandom_range(1023, 1010));
         default: return 10'($urandom_range(1023));
      endcase
   endfunction

   // A well-formed scan with random content: a lobe of light around some sensor.
   task automatic send_random_scan();
      int       peak, base, lift, gap;
      bit [9:0] value;
      peak = $urandom_range(RING - 1);
      base = $urandom_range(300);
      lift = $urandom_range(700);
      for (int k = 0; k < RING; k++) begin
         gap = (k - peak + RING) % RING;
         if (gap > RING / 2) gap = RING - gap;
         if ($urandom_range(7) == 0) value = random_level();
         else if ($urandom_range(3) == 0) value = 10'($urandom_range(1023));
         else value = 10'(base + (gap < 4 ? lift * (4 - gap) / 4 : 0));
         send_reading(value, k == 0);
      end
   endtask

   // Readings with stray start marks; later complete scans overwrite them.
   task automatic send_noise();
      int run;
      run = $urandom_range(1, 30);
      for (int k = 0; k < run; k++)
         send_reading(10'($urandom_range(1023)), $urandom_range(7) == 0);
   endtask

   task automatic run_phase(int scans, int idle);
      idle_pct = idle;
      for (int n = 0; n < scans; n++) begin
         if ($urandom_range(9) == 0) send_noise();
         send_random_scan();
      end
   endtask

   // Compare each strobed result with the oldest expectation.
   always @(negedge clock) begin
      bearing_type want;
      if (!reset && rsp_valid) begin
         if (pending_bearings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: bearing %0d zero %0d", rsp_bearing, rsp_vector_zero);
         end else begin
            want = pending_bearings.pop_front();
            if (rsp_bearing !== want.bearing || rsp_vector_zero !== want.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("bearing mismatch: expected %0d/%0d, got %0d/%0d",
                           want.bearing, want.zero, rsp_bearing, rsp_vector_zero);
            end
         end
      end
   end

   scan_row_type directed_scans [6] = '{
      '{SHAPE_FLAT,   512,  0, 1'b1, 15'd11520, 1'b1},
      '{SHAPE_FLAT,   0,    0, 1'b1, 15'd11520, 1'b1},
      '{SHAPE_FLAT,   1023, 0, 1'b1, 15'd11520, 1'b1},
      '{SHAPE_SPIKE,  1020, 0, 1'b0, 15'd0,     1'b0},
      '{SHAPE_SPIKE,  900,  6, 1'b0, 15'd0,     1'b0},
      '{SHAPE_BROKEN, 700,  9, 1'b0, 15'd0,     1'b0}
   };

   initial begin
      srbe_pkg::cfg_type next;
      bit [9:0]          value;
      int                last_slot;
      reset             = 1'b1;
      start             = 1'b0;
      req_sample        = '0;
      req_start_of_scan = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = srbe_pkg::CSR_LOW_LIMIT;
      csr_write_data    = '0;
      mismatches        = 0;
      idle_pct          = 0;
      ring_count        = 0;
      cfg = '{srbe_pkg::LOW_LIMIT_RESET, srbe_pkg::HIGH_LIMIT_RESET,
              srbe_pkg::PATCH_ENABLE_RESET, srbe_pkg::PATCHED_SENSOR_RESET};
      build_weights();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed scans under the reset settings.
      foreach (directed_scans[r]) begin
         // a broken scan first feeds a few readings, then restarts on a mark
         if (directed_scans[r].shape == SHAPE_BROKEN)
            for (int k = 0; k < directed_scans[r].spot; k++) send_reading(10'd1023, k == 0);
         for (int k = 0; k < RING; k++) begin
            if (directed_scans[r].shape == SHAPE_FLAT) value = 10'(directed_scans[r].level);
            else if (k == directed_scans[r].spot) value = 10'(directed_scans[r].level);
            else value = 10'd100;
            send_reading(value, k == 0);
         end
         // the scan just completed is always the newest expectation
         if (directed_scans[r].known && pending_bearings.size() > 0) begin
            last_slot = pending_bearings.size() - 1;
            pending_bearings[last_slot].bearing = directed_scans[r].bearing;
            pending_bearings[last_slot].zero    = directed_scans[r].zero;
         end
      end

      run_phase(10, 0);
      next = '{10'd0, 10'd1023, 1'b0, 5'd0};        // nothing repaired, no patch
      write_registers(next);
      run_phase(10, 73);
      next = '{10'd1023, 10'd0, 1'b1, 5'd0};        // low above high: all repaired
      write_registers(next);
      run_phase(8, 8);
      next = '{10'd682, 10'd341, 1'b1, 5'd31};      // patch index out of range
      write_registers(next);
      run_phase(8, 0);
      next = '{10'd100, 10'd900, 1'b1, 5'd23};
      write_registers(next);
      run_phase(10, 73);
      next = '{10'd341, 10'd682, 1'b1, 5'd21};
      write_registers(next);
      run_phase(10, 8);
      next = '{10'($urandom_range(20)), 10'($urandom_range(1023, 1000)), 1'b1, 5'd10};
      write_registers(next);
      run_phase(6, 0);

      start <= 1'b0;
      wait (pending_bearings.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_bearings.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
